>>> rtl/arm_abe_pkg.sv
package arm_abe_pkg;

    // Architectural constants
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned FLAGS_W   = 4;

    localparam logic [WORD_W-1:0] PC_RESET    = 32'hFFFF_0008;
    localparam logic [WORD_W-1:0] PANIC_RESET = 32'hFFFF_0588;
    localparam logic [WORD_W-1:0] BX_PATTERN  = 32'h012F_FF10;
    localparam logic [WORD_W-1:0] BX_MASK     = 32'h0FFF_FFF0;
    localparam logic [WORD_W-1:0] PC_STEP     = 32'd4;
    localparam logic [WORD_W-1:0] PC_AHEAD    = 32'd8;

    localparam logic [REG_IDX_W-1:0] REG_LR = 4'd14;
    localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_EXEC      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_COND_FAIL = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNSUP     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_PANIC     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_THUMB     = 3'd4;

    // Condition codes handled here
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_AL = 4'hE;

    // Data-processing opcodes
    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_CMN = 4'hB;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;
    localparam logic [3:0] OP_BIC = 4'hE;

    // Immediate shift types
    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;

    // Instruction class field (bits 27:25)
    localparam logic [2:0] CLASS_BRANCH = 3'b101;

    // Everything one instruction leaves behind
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [WORD_W-1:0]    pc;
        logic [FLAGS_W-1:0]   flags;
        logic                 thumb;
        logic                 wr;
        logic [REG_IDX_W-1:0] widx;
        logic [WORD_W-1:0]    wval;
    } t_exec_res;

endpackage

>>> rtl/arm_abe_ram.sv
module arm_abe_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr_a,
    input  logic [$clog2(Depth)-1:0] i_rd_addr_b,
    output logic [Width-1:0]         o_rd_data_a,
    output logic [Width-1:0]         o_rd_data_b
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_a;
    logic [Width-1:0] r_rd_b;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> rtl/arm_abe_exec.sv
module arm_abe_exec (
    input  logic [arm_abe_pkg::WORD_W-1:0]  i_ins,
    input  logic [arm_abe_pkg::WORD_W-1:0]  i_op_n,
    input  logic [arm_abe_pkg::WORD_W-1:0]  i_op_m,
    input  logic [arm_abe_pkg::WORD_W-1:0]  i_pc,
    input  logic [arm_abe_pkg::WORD_W-1:0]  i_panic,
    input  logic [arm_abe_pkg::FLAGS_W-1:0] i_flags,
    input  logic                            i_thumb,
    output arm_abe_pkg::t_exec_res          o_res
);

    always_comb begin
        logic        n, z, c, v;
        logic        cond_ok, cond_pass;
        logic        ok, writes, logical;
        logic [31:0] b, res, off, target, t;
        logic [32:0] sum, diff;
        logic [63:0] rot;
        logic [4:0]  sh;
        logic [3:0]  op;

        n = i_flags[3];
        z = i_flags[2];
        c = i_flags[1];
        v = i_flags[0];

        o_res.status = arm_abe_pkg::STAT_EXEC;
        o_res.pc     = i_pc;
        o_res.flags  = i_flags;
        o_res.thumb  = i_thumb;
        o_res.wr     = 1'b0;
        o_res.widx   = '0;
        o_res.wval   = '0;

        // Condition check
        cond_ok   = 1'b1;
        cond_pass = 1'b0;
        unique case (i_ins[31:28])
            arm_abe_pkg::COND_EQ: cond_pass = z;
            arm_abe_pkg::COND_NE: cond_pass = ~z;
            arm_abe_pkg::COND_CS: cond_pass = c;
            arm_abe_pkg::COND_CC: cond_pass = ~c;
            arm_abe_pkg::COND_PL: cond_pass = ~n;
            arm_abe_pkg::COND_HI: cond_pass = c & ~z;
            arm_abe_pkg::COND_LS: cond_pass = ~c | z;
            arm_abe_pkg::COND_LT: cond_pass = v ^ n;
            arm_abe_pkg::COND_AL: cond_pass = 1'b1;
            default:              cond_ok   = 1'b0;
        endcase

        // Branch target and BX target
        off    = {{6{i_ins[23]}}, i_ins[23:0], 2'b00};
        target = i_pc + off;
        t      = i_op_m;

        // Second operand: rotated immediate or shifted register
        ok  = 1'b1;
        sh  = i_ins[11:7];
        rot = {24'd0, i_ins[7:0], 24'd0, i_ins[7:0]} >> {i_ins[11:8], 1'b0};
        b   = i_op_m;
        if (i_ins[25]) begin
            b = rot[31:0];
        end else if (i_ins[4]) begin
            ok = 1'b0;
        end else if (i_ins[6:5] == arm_abe_pkg::SHIFT_LSL) begin
            b = i_op_m << sh;
        end else if (i_ins[6:5] == arm_abe_pkg::SHIFT_LSR) begin
            b = (sh == 5'd0) ? 32'd0 : (i_op_m >> sh);
        end else begin
            ok = 1'b0;
        end

        op = i_ins[24:21];
        if (op[3:2] == 2'b10 && !i_ins[20]) begin
            ok = 1'b0;
        end

        // ALU
        sum     = {1'b0, i_op_n} + {1'b0, b};
        diff    = {1'b0, i_op_n} - {1'b0, b};
        res     = '0;
        writes  = 1'b1;
        logical = 1'b1;
        unique case (op)
            arm_abe_pkg::OP_AND: res = i_op_n & b;
            arm_abe_pkg::OP_EOR: res = i_op_n ^ b;
            arm_abe_pkg::OP_SUB, arm_abe_pkg::OP_CMP: begin
                res     = diff[31:0];
                logical = 1'b0;
                c       = ~diff[32];
                v       = (i_op_n[31] ^ b[31]) & (i_op_n[31] ^ res[31]);
                writes  = (op == arm_abe_pkg::OP_SUB);
            end
            arm_abe_pkg::OP_ADD, arm_abe_pkg::OP_CMN: begin
                res     = sum[31:0];
                logical = 1'b0;
                c       = sum[32];
                v       = ~(i_op_n[31] ^ b[31]) & (i_op_n[31] ^ res[31]);
                writes  = (op == arm_abe_pkg::OP_ADD);
            end
            arm_abe_pkg::OP_TST: begin
                res    = i_op_n & b;
                writes = 1'b0;
            end
            arm_abe_pkg::OP_ORR: res = i_op_n | b;
            arm_abe_pkg::OP_MOV: res = b;
            arm_abe_pkg::OP_BIC: res = i_op_n & ~b;
            default:             ok  = 1'b0;
        endcase

        // Pick the outcome by instruction class
        priority if (i_thumb) begin
            o_res.status = arm_abe_pkg::STAT_THUMB;
        end else if (!cond_ok) begin
            o_res.status = arm_abe_pkg::STAT_UNSUP;
        end else if (!cond_pass) begin
            o_res.status = arm_abe_pkg::STAT_COND_FAIL;
            o_res.pc     = i_pc + arm_abe_pkg::PC_STEP;
        end else if ((i_ins & arm_abe_pkg::BX_MASK) == arm_abe_pkg::BX_PATTERN) begin
            o_res.thumb = t[0];
            o_res.pc    = {t[31:1], 1'b0}
                        + (t[0] ? arm_abe_pkg::PC_STEP : arm_abe_pkg::PC_AHEAD);
        end else if (i_ins[27:25] == arm_abe_pkg::CLASS_BRANCH) begin
            if (target == i_panic) begin
                o_res.status = arm_abe_pkg::STAT_PANIC;
            end else begin
                if (i_ins[24]) begin
                    o_res.wr   = 1'b1;
                    o_res.widx = arm_abe_pkg::REG_LR;
                    o_res.wval = i_pc - arm_abe_pkg::PC_STEP;
                end
                o_res.pc = target + arm_abe_pkg::PC_AHEAD;
            end
        end else if (i_ins[27:26] != 2'b00 || !ok) begin
            o_res.status = arm_abe_pkg::STAT_UNSUP;
        end else begin
            if (i_ins[20]) begin
                o_res.flags = {res[31], (res == 32'd0), (c & ~logical), v};
            end
            if (writes && i_ins[15:12] == arm_abe_pkg::REG_PC) begin
                o_res.pc = res + arm_abe_pkg::PC_AHEAD;
            end else begin
                if (writes) begin
                    o_res.wr   = 1'b1;
                    o_res.widx = i_ins[15:12];
                    o_res.wval = res;
                end
                o_res.pc = i_pc + arm_abe_pkg::PC_STEP;
            end
        end
    end

endmodule

>>> rtl/arm_alu_branch_execute.sv
// Channel   | Direction | Handshake                 | Word
// ----------+-----------+---------------------------+---------------------------------------
// in        | in        | i_in_valid / o_in_stall   | i_instruction_word
// out       | out       | o_out_valid / i_out_stall | o_status, o_next_fetch_address,
//           |           |                           | o_reg_written, o_reg_index,
//           |           |                           | o_reg_value, o_flags_nzcv
// cfg       | in        | i_cfg_wr_en               | i_cfg_wr_data (panic address)
//
// One instruction per cycle unless the output stalls; each result is registered for output.
// The register file read is registered at input acceptance; a write from the instruction
// executing in that same cycle is forwarded, so dependent words run back to back.
// Synchronous active-low reset clears registers to zero, PC to fetch 0xFFFF0000, flags,
// thumb, and the panic address to its default; no clearing pass is needed.
// A stall on the output holds the result and, once the input register is full, stalls
// the input.
module arm_alu_branch_execute (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [arm_abe_pkg::WORD_W-1:0]      i_instruction_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [arm_abe_pkg::STATUS_W-1:0]    o_status,
    output logic [arm_abe_pkg::WORD_W-1:0]      o_next_fetch_address,
    output logic                                o_reg_written,
    output logic [arm_abe_pkg::REG_IDX_W-1:0]   o_reg_index,
    output logic [arm_abe_pkg::WORD_W-1:0]      o_reg_value,
    output logic [arm_abe_pkg::FLAGS_W-1:0]     o_flags_nzcv,
    input  logic                                i_cfg_wr_en,
    input  logic [arm_abe_pkg::WORD_W-1:0]      i_cfg_wr_data
);

    logic                                   r_in_vld, n_in_vld;
    logic [arm_abe_pkg::WORD_W-1:0]         r_ins;
    logic                                   r_out_vld, n_out_vld;
    logic [arm_abe_pkg::WORD_W-1:0]         r_pc;
    logic [arm_abe_pkg::FLAGS_W-1:0]        r_flags;
    logic                                   r_thumb;
    logic [arm_abe_pkg::WORD_W-1:0]         r_panic;
    logic [arm_abe_pkg::REG_COUNT-1:0]      r_gpr_vld;
    logic                                   r_n_byp, r_m_byp;
    logic [arm_abe_pkg::WORD_W-1:0]         r_n_byp_val, r_m_byp_val;
    logic [arm_abe_pkg::STATUS_W-1:0]       r_status;
    logic [arm_abe_pkg::WORD_W-1:0]         r_next_fetch;
    logic                                   r_wr;
    logic [arm_abe_pkg::REG_IDX_W-1:0]      r_widx;
    logic [arm_abe_pkg::WORD_W-1:0]         r_wval;
    logic [arm_abe_pkg::FLAGS_W-1:0]        r_flags_out;

    logic                                   accept, exec_go, commit_wr;
    logic [arm_abe_pkg::REG_IDX_W-1:0]      in_rn, in_rm, ex_rn, ex_rm;
    logic [arm_abe_pkg::WORD_W-1:0]         ram_n, ram_m, op_n, op_m;
    logic                                   hit_n, hit_m;
    arm_abe_pkg::t_exec_res                 ex_res;

    // Handshake
    assign exec_go    = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~exec_go;
    assign accept     = i_in_valid & ~o_in_stall;
    assign commit_wr  = exec_go & ex_res.wr;

    assign in_rn = i_instruction_word[19:16];
    assign in_rm = i_instruction_word[3:0];
    assign ex_rn = r_ins[19:16];
    assign ex_rm = r_ins[3:0];

    // Input register
    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (exec_go) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_instruction_word;
        end
    end

    // Register file
    arm_abe_ram #(
        .Width (arm_abe_pkg::WORD_W),
        .Depth (arm_abe_pkg::REG_COUNT)
    ) u_gpr (
        .i_clk       (i_clk),
        .i_wr_en     (commit_wr),
        .i_wr_addr   (ex_res.widx),
        .i_wr_data   (ex_res.wval),
        .i_rd_en     (accept),
        .i_rd_addr_a (in_rn),
        .i_rd_addr_b (in_rm),
        .o_rd_data_a (ram_n),
        .o_rd_data_b (ram_m)
    );

    // Forward a same-cycle write, read never-written registers as zero
    assign hit_n = commit_wr & (ex_res.widx == in_rn);
    assign hit_m = commit_wr & (ex_res.widx == in_rm);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n_byp     <= hit_n | ~r_gpr_vld[in_rn];
            r_m_byp     <= hit_m | ~r_gpr_vld[in_rm];
            r_n_byp_val <= hit_n ? ex_res.wval : '0;
            r_m_byp_val <= hit_m ? ex_res.wval : '0;
        end
    end

    // Resolve operands, r15 reads the PC
    assign op_n = (ex_rn == arm_abe_pkg::REG_PC) ? r_pc : (r_n_byp ? r_n_byp_val : ram_n);
    assign op_m = (ex_rm == arm_abe_pkg::REG_PC) ? r_pc : (r_m_byp ? r_m_byp_val : ram_m);

    arm_abe_exec u_exec (
        .i_ins   (r_ins),
        .i_op_n  (op_n),
        .i_op_m  (op_m),
        .i_pc    (r_pc),
        .i_panic (r_panic),
        .i_flags (r_flags),
        .i_thumb (r_thumb),
        .o_res   (ex_res)
    );

    // Architectural state, advance on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= arm_abe_pkg::PC_RESET;
            r_flags   <= '0;
            r_thumb   <= 1'b0;
            r_gpr_vld <= '0;
        end else if (exec_go) begin
            r_pc    <= ex_res.pc;
            r_flags <= ex_res.flags;
            r_thumb <= ex_res.thumb;
            if (ex_res.wr) begin
                r_gpr_vld[ex_res.widx] <= 1'b1;
            end
        end
    end

    // Panic address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panic <= arm_abe_pkg::PANIC_RESET;
        end else if (i_cfg_wr_en) begin
            r_panic <= i_cfg_wr_data;
        end
    end

    // Result register
    always_comb begin
        n_out_vld = r_out_vld & i_out_stall;
        if (exec_go) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status     <= ex_res.status;
            r_next_fetch <= ex_res.pc - arm_abe_pkg::PC_AHEAD;
            r_wr         <= ex_res.wr;
            r_widx       <= ex_res.widx;
            r_wval       <= ex_res.wval;
            r_flags_out  <= ex_res.flags;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_status             = r_status;
    assign o_next_fetch_address = r_next_fetch;
    assign o_reg_written        = r_wr;
    assign o_reg_index          = r_widx;
    assign o_reg_value          = r_wval;
    assign o_flags_nzcv         = r_flags_out;

endmodule

>>> rtl/arm_abe_chk.sv
module arm_abe_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [arm_abe_pkg::WORD_W-1:0]    i_instruction_word,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [arm_abe_pkg::STATUS_W-1:0]  o_status,
    input logic [arm_abe_pkg::WORD_W-1:0]    o_next_fetch_address,
    input logic                              o_reg_written,
    input logic [arm_abe_pkg::REG_IDX_W-1:0] o_reg_index,
    input logic [arm_abe_pkg::WORD_W-1:0]    o_reg_value,
    input logic [arm_abe_pkg::FLAGS_W-1:0]   o_flags_nzcv
);

    // Hold a stalled input word
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_instruction_word))
        else $error("stalled input word changed");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_next_fetch_address) && $stable(o_reg_written)
            && $stable(o_reg_index) && $stable(o_reg_value) && $stable(o_flags_nzcv))
        else $error("stalled result word changed");

    // Only an executed word writes a register
    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reg_written |-> o_status == arm_abe_pkg::STAT_EXEC)
        else $error("register write reported without execution");

    // A write to r15 redirects fetch and is never reported
    a_write_not_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reg_written |-> o_reg_index != arm_abe_pkg::REG_PC)
        else $error("r15 reported as a register write");

    // No write leaves index and value at zero
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reg_written |-> o_reg_index == '0 && o_reg_value == '0)
        else $error("index or value set without a write");

endmodule

bind arm_alu_branch_execute arm_abe_chk u_arm_abe_chk (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import arm_abe_pkg::*;

    localparam int CLK_HALF_NS    = 6;
    localparam longint TIMEOUT_NS = 64'd12_000_000;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 96;

    // Encodings that the block rejects, used to build stimulus
    localparam logic [3:0] COND_MI   = 4'h4;
    localparam logic [3:0] COND_NV   = 4'hF;
    localparam logic [3:0] OP_RSB    = 4'h3;
    localparam logic [3:0] OP_ADC    = 4'h5;
    localparam logic [3:0] OP_TEQ    = 4'h9;
    localparam logic [3:0] OP_MVN    = 4'hF;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    typedef enum logic [1:0] {CC_PASS, CC_FAIL, CC_BAD} t_cc_verdict;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [WORD_W-1:0]    fetch;
        logic                 wr;
        logic [REG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    value;
        logic [FLAGS_W-1:0]   nzcv;
    } t_retire;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [WORD_W-1:0] in_word = '0;
    logic              out_stall = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [WORD_W-1:0] cfg_wr_data = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [WORD_W-1:0]    o_next_fetch_address;
    logic                 o_reg_written;
    logic [REG_IDX_W-1:0] o_reg_index;
    logic [WORD_W-1:0]    o_reg_value;
    logic [FLAGS_W-1:0]   o_flags_nzcv;

    // Architectural shadow of the core
    logic [WORD_W-1:0]  arch_gpr [15] = '{default: '0};
    logic [WORD_W-1:0]  arch_pc = PC_RESET;
    logic [FLAGS_W-1:0] arch_nzcv = '0;
    logic               arch_thumb = 1'b0;
    logic [WORD_W-1:0]  arch_panic = PANIC_RESET;

    logic [WORD_W-1:0] fetch_q [$];
    t_retire           retire_q [$];

    int gap_left = 0;
    int calm_left = 0;
    int hold_left = 0;
    int quiet_left = 0;
    int mismatch_count = 0;

    logic [3:0] good_conds [9] = '{COND_EQ, COND_NE, COND_CS, COND_CC, COND_PL,
                                   COND_HI, COND_LS, COND_LT, COND_AL};
    logic [3:0] good_ops [10] = '{OP_AND, OP_EOR, OP_SUB, OP_ADD, OP_TST,
                                  OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC};

    arm_alu_branch_execute dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_instruction_word   (in_word),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_status             (o_status),
        .o_next_fetch_address (o_next_fetch_address),
        .o_reg_written        (o_reg_written),
        .o_reg_index          (o_reg_index),
        .o_reg_value          (o_reg_value),
        .o_flags_nzcv         (o_flags_nzcv),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_wr_data        (cfg_wr_data)
    );

    initial begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // Instruction predictor
    // ---------------------------------------------------------------

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] r);
        logic [63:0] both;
        both = {x, x} >> r;
        return both[31:0];
    endfunction

    function automatic logic [WORD_W-1:0] read_gpr(input logic [3:0] idx);
        return (idx == REG_PC) ? arch_pc : arch_gpr[idx];
    endfunction

    function automatic t_cc_verdict cond_verdict(input logic [3:0] cc);
        logic n, z, c, v;
        {n, z, c, v} = arch_nzcv;
        case (cc)
            COND_EQ: return z ? CC_PASS : CC_FAIL;
            COND_NE: return !z ? CC_PASS : CC_FAIL;
            COND_CS: return c ? CC_PASS : CC_FAIL;
            COND_CC: return !c ? CC_PASS : CC_FAIL;
            COND_PL: return !n ? CC_PASS : CC_FAIL;
            COND_HI: return (c && !z) ? CC_PASS : CC_FAIL;
            COND_LS: return (!c || z) ? CC_PASS : CC_FAIL;
            COND_LT: return (v != n) ? CC_PASS : CC_FAIL;
            COND_AL: return CC_PASS;
            default: return CC_BAD;
        endcase
    endfunction

    // Execute one word on the shadow state and queue what the core should retire
    task automatic execute_word(input logic [WORD_W-1:0] w);
        t_retire     r;
        t_cc_verdict verdict;
        logic [WORD_W-1:0] a, b, res, tgt, off;
        logic [32:0] sum;
        logic [3:0]  op, rd;
        logic [4:0]  amt;
        logic [1:0]  sty;
        logic        s, ok, writes, logical, n, z, c, v;
        r = '0;
        r.status = STAT_EXEC;
        verdict = cond_verdict(w[31:28]);
        if (arch_thumb) begin
            r.status = STAT_THUMB;
        end else if (verdict == CC_BAD) begin
            r.status = STAT_UNSUP;
        end else if (verdict == CC_FAIL) begin
            r.status = STAT_COND_FAIL;
            arch_pc += PC_STEP;
        end else if ((w & BX_MASK) == BX_PATTERN) begin
            tgt = read_gpr(w[3:0]);
            if (tgt[0]) arch_thumb = 1'b1;
            arch_pc = {tgt[31:1], 1'b0} + (arch_thumb ? PC_STEP : PC_AHEAD);
        end else if (w[27:25] == CLASS_BRANCH) begin
            off = {{6{w[23]}}, w[23:0], 2'b00};
            tgt = arch_pc + off;
            if (tgt == arch_panic) begin
                r.status = STAT_PANIC;
            end else begin
                if (w[24]) begin
                    arch_gpr[REG_LR] = arch_pc - PC_STEP;
                    r.wr = 1'b1;
                    r.idx = REG_LR;
                    r.value = arch_pc - PC_STEP;
                end
                arch_pc = tgt + PC_AHEAD;
            end
        end else if (w[27:26] != 2'b00) begin
            r.status = STAT_UNSUP;
        end else begin
            op = w[24:21];
            s = w[20];
            rd = w[15:12];
            a = read_gpr(w[19:16]);
            res = '0;
            ok = 1'b1;
            writes = 1'b1;
            logical = 1'b1;
            // second operand: rotated immediate or register shifted by an immediate
            if (w[25]) begin
                b = rotr32({24'd0, w[7:0]}, {w[11:8], 1'b0});
            end else begin
                amt = w[11:7];
                sty = w[6:5];
                b = read_gpr(w[3:0]);
                if (w[4]) ok = 1'b0;
                else if (sty == SHIFT_LSL) b = b << amt;
                else if (sty == SHIFT_LSR) b = (amt == 0) ? '0 : (b >> amt);
                else ok = 1'b0;
            end
            if (op >= OP_TST && op <= OP_CMN && !s) ok = 1'b0;
            {n, z, c, v} = arch_nzcv;
            if (ok) begin
                case (op)
                    OP_AND: res = a & b;
                    OP_EOR: res = a ^ b;
                    OP_SUB, OP_CMP: begin
                        res = a - b;
                        logical = 1'b0;
                        c = (a >= b);
                        v = (a[31] ^ b[31]) & (a[31] ^ res[31]);
                        writes = (op != OP_CMP);
                    end
                    OP_ADD, OP_CMN: begin
                        sum = {1'b0, a} + {1'b0, b};
                        res = sum[31:0];
                        logical = 1'b0;
                        c = sum[32];
                        v = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
                        writes = (op != OP_CMN);
                    end
                    OP_TST: begin
                        res = a & b;
                        writes = 1'b0;
                    end
                    OP_ORR: res = a | b;
                    OP_MOV: res = b;
                    OP_BIC: res = a & ~b;
                    default: ok = 1'b0;
                endcase
            end
            if (!ok) begin
                r.status = STAT_UNSUP;
            end else begin
                if (s) begin
                    n = res[31];
                    z = (res == '0);
                    if (logical) c = 1'b0;
                    arch_nzcv = {n, z, c, v};
                end
                if (writes && rd == REG_PC) begin
                    arch_pc = res + PC_AHEAD;
                end else begin
                    if (writes) begin
                        arch_gpr[rd] = res;
                        r.wr = 1'b1;
                        r.idx = rd;
                        r.value = res;
                    end
                    arch_pc += PC_STEP;
                end
            end
        end
        r.fetch = arch_pc - PC_AHEAD;
        r.nzcv = arch_nzcv;
        retire_q.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Encoders and random picks
    // ---------------------------------------------------------------

    function automatic logic [WORD_W-1:0] dp_word(input logic [3:0] cc, input logic imm,
                                                  input logic [3:0] op, input logic s,
                                                  input logic [3:0] rn, input logic [3:0] rd,
                                                  input logic [11:0] op2);
        return {cc, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic logic [11:0] reg_op2(input logic [4:0] amt, input logic [1:0] sty,
                                            input logic [3:0] rm);
        return {amt, sty, 1'b0, rm};
    endfunction

    function automatic logic [WORD_W-1:0] br_word(input logic [3:0] cc, input logic link,
                                                  input logic [23:0] off24);
        return {cc, CLASS_BRANCH, link, off24};
    endfunction

    function automatic logic [WORD_W-1:0] bx_word(input logic [3:0] cc, input logic [3:0] rm);
        return {cc, BX_PATTERN[27:4], rm};
    endfunction

    function automatic logic [3:0] pick_cond();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return COND_AL;
        if (k < 90) return good_conds[$urandom_range(0, 8)];
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        logic [23:0] off24;
        logic [11:0] op2;
        logic [3:0]  op, rd, rn;
        logic [1:0]  sty;
        logic        s, imm, link;
        int          k, near;
        k = $urandom_range(0, 99);
        if (k < 12) begin
            w = $urandom();
        end else if (k < 28) begin
            near = int'($urandom_range(0, 511)) - 256;
            off24 = ($urandom_range(0, 9) < 7) ? near[23:0] : 24'($urandom());
            link = 1'($urandom_range(0, 1));
            w = br_word(pick_cond(), link, off24);
        end else begin
            op = ($urandom_range(0, 99) < 85) ? good_ops[$urandom_range(0, 9)]
                                               : 4'($urandom_range(0, 15));
            s = 1'($urandom_range(0, 1));
            if (op >= OP_TST && op <= OP_CMN && $urandom_range(0, 9) != 0) s = 1'b1;
            rd = ($urandom_range(0, 99) < 8) ? REG_PC : 4'($urandom_range(0, 14));
            rn = 4'($urandom_range(0, 15));
            imm = 1'($urandom_range(0, 1));
            op2 = 12'($urandom());
            if (!imm) begin
                sty = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
                                                    : 2'($urandom_range(2, 3));
                op2[6:5] = sty;
                op2[4] = ($urandom_range(0, 99) < 8);
                if (op2[4]) op2[7] = 1'b0;
            end
            w = dp_word(pick_cond(), imm, op, s, rn, rd, op2);
        end
        // never let a random word switch the core to thumb
        if ((w & BX_MASK) == BX_PATTERN) w[4] = 1'b0;
        return w;
    endfunction

    function automatic int gap_length();
        int k;
        k = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (k < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (k < 55) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int stall_length();
        int k;
        k = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if (k < 2) begin
            quiet_left = $urandom_range(30, 100);
            return 0;
        end
        if (k < 70) return 0;
        if (k < 92) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // ---------------------------------------------------------------
    // Driver and monitor
    // ---------------------------------------------------------------

    // Present fetched words, hold them while stalled, predict on acceptance
    always @(posedge clk) begin : driver
        logic              next_valid;
        logic [WORD_W-1:0] next_word;
        next_valid = in_valid;
        next_word = in_word;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                execute_word(in_word);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (fetch_q.size() > 0) begin
                    next_word = fetch_q.pop_front();
                    next_valid = 1'b1;
                    gap_left = gap_length();
                end
            end
        end
        in_valid <= next_valid;
        in_word <= next_word;
    end

    // Compare each retired word with the oldest prediction; stall at random
    always @(posedge clk) begin : monitor
        t_retire want;
        logic    bad;
        if (rst_n && o_out_valid && !out_stall) begin
            if (retire_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: status %0d fetch %h", o_status,
                             o_next_fetch_address);
            end else begin
                want = retire_q.pop_front();
                bad = (o_status !== want.status) || (o_next_fetch_address !== want.fetch) ||
                      (o_reg_written !== want.wr) || (o_reg_index !== want.idx) ||
                      (o_reg_value !== want.value) || (o_flags_nzcv !== want.nzcv);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch exp/act: status %0d/%0d fetch %h/%h ",
                                  "wr %0d/%0d idx %0d/%0d value %h/%h nzcv %b/%b"},
                                 want.status, o_status, want.fetch, o_next_fetch_address,
                                 want.wr, o_reg_written, want.idx, o_reg_index,
                                 want.value, o_reg_value, want.nzcv, o_flags_nzcv);
                end
            end
        end
        if (hold_left == 0) hold_left = stall_length();
        out_stall <= (hold_left != 0);
        if (hold_left != 0) hold_left--;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Wait until every queued word has been taken and has retired
    task automatic drain();
        while (fetch_q.size() != 0 || in_valid || retire_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_panic(input logic [WORD_W-1:0] addr);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        arch_panic = addr;
    endtask

    task automatic queue_random(input int count);
        logic [3:0]  rx;
        logic [11:0] imm12;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                // load an even target, then branch-exchange to it in ARM state
                rx = 4'($urandom_range(0, 14));
                imm12 = 12'($urandom());
                while ((rotr32({24'd0, imm12[7:0]}, {imm12[11:8], 1'b0}) & 32'd1) != 0)
                    imm12 = 12'($urandom());
                fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, rx, imm12));
                fetch_q.push_back(bx_word(pick_cond(), rx));
            end else begin
                fetch_q.push_back(random_word());
            end
        end
    endtask

    initial begin : stimulus
        logic [WORD_W-1:0] target;
        logic [23:0]       off24;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // branch onto the default panic address, plain and with link
        fetch_q.push_back(br_word(COND_AL, 1'b0, 24'h000160));
        fetch_q.push_back(br_word(COND_AL, 1'b1, 24'h000160));
        // immediates at both rotation extremes, MOVS setting N
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd0, 12'h0FF));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h102));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd2, 12'hFFF));
        // add to zero with carry and overflow, then conditions on it
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, 4'd1, 4'd3,
                                  reg_op2(5'd0, SHIFT_LSL, 4'd1)));
        fetch_q.push_back(dp_word(COND_HI, 1'b1, OP_ADD, 1'b0, 4'd4, 4'd4, 12'h001));
        fetch_q.push_back(dp_word(COND_LS, 1'b1, OP_ADD, 1'b0, 4'd4, 4'd4, 12'h001));
        // subtract with the largest left shift, signed overflow
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_SUB, 1'b1, 4'd0, 4'd5,
                                  reg_op2(5'd31, SHIFT_LSL, 4'd0)));
        fetch_q.push_back(dp_word(COND_LT, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd6, 12'h001));
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_CMP, 1'b1, 4'd0, 4'd0,
                                  reg_op2(5'd0, SHIFT_LSL, 4'd0)));
        // read of the program counter
        fetch_q.push_back(dp_word(COND_EQ, 1'b1, OP_ADD, 1'b0, REG_PC, 4'd7, 12'h000));
        // LSR by zero means a shift by 32
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_CMN, 1'b1, 4'd1, 4'd0,
                                  reg_op2(5'd0, SHIFT_LSR, 4'd1)));
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_TST, 1'b1, 4'd0, 4'd0,
                                  reg_op2(5'd2, SHIFT_LSR, 4'd2)));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_EOR, 1'b1, 4'd0, 4'd8, 12'h0FF));
        fetch_q.push_back(dp_word(COND_NE, 1'b0, OP_ORR, 1'b0, 4'd1, 4'd9,
                                  reg_op2(5'd31, SHIFT_LSR, 4'd0)));
        fetch_q.push_back(dp_word(COND_PL, 1'b1, OP_BIC, 1'b1, 4'd0, 4'd10, 12'h00F));
        fetch_q.push_back(dp_word(COND_CC, 1'b0, OP_AND, 1'b1, 4'd0, 4'd14,
                                  reg_op2(5'd0, SHIFT_LSL, 4'd2)));
        // write to the program counter
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, REG_PC, 12'h000));
        // unsupported condition codes and forms
        fetch_q.push_back(dp_word(COND_MI, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd1, 12'h001));
        fetch_q.push_back(dp_word(COND_NV, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd1, 12'h001));
        fetch_q.push_back({COND_AL, 28'h590_1000});
        fetch_q.push_back({COND_AL, 28'h8BD_0001});
        fetch_q.push_back({COND_AL, 28'hE00_0010});
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_ADD, 1'b0, 4'd0, 4'd1,
                                  {4'd2, 1'b0, SHIFT_LSL, 1'b1, 4'd0}));
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_MOV, 1'b0, 4'd0, 4'd1,
                                  reg_op2(5'd1, SHIFT_ASR, 4'd0)));
        fetch_q.push_back(dp_word(COND_AL, 1'b0, OP_MOV, 1'b0, 4'd0, 4'd1,
                                  reg_op2(5'd1, SHIFT_ROR, 4'd0)));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_RSB, 1'b0, 4'd0, 4'd1, 12'h001));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_ADC, 1'b1, 4'd0, 4'd1, 12'h001));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MVN, 1'b0, 4'd0, 4'd1, 12'h001));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_TST, 1'b0, 4'd0, 4'd0, 12'h001));
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_TEQ, 1'b1, 4'd0, 4'd0, 12'h001));
        // branch-exchange in ARM state, then branches at the offset extremes
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd12, 12'h040));
        fetch_q.push_back(bx_word(COND_AL, 4'd12));
        fetch_q.push_back(br_word(COND_AL, 1'b1, 24'h7FFFFF));
        fetch_q.push_back(br_word(COND_CS, 1'b0, 24'h800000));

        // random phases, each under its own panic address
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_panic(32'hFFFF_FFFF);
                1: begin
                    write_panic(32'h0000_0000);
                    // jump to zero, then branch back onto address zero
                    fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, REG_PC,
                                              12'h000));
                    fetch_q.push_back(br_word(COND_AL, 1'b0, 24'hFFFFFE));
                    fetch_q.push_back(br_word(COND_AL, 1'b1, 24'hFFFFFE));
                end
                2: write_panic($urandom());
                4: write_panic(PANIC_RESET);
                default: begin
                    drain();
                    off24 = 24'($urandom());
                    target = arch_pc + {{6{off24[23]}}, off24, 2'b00};
                    write_panic(target);
                    fetch_q.push_back(br_word(COND_AL, (p == 5), off24));
                end
            endcase
            queue_random(PHASE_WORDS);
        end

        // enter thumb last: nothing executes after it
        drain();
        fetch_q.push_back(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd0, 12'h001));
        fetch_q.push_back(bx_word(COND_AL, 4'd0));
        for (int i = 0; i < 12; i++) fetch_q.push_back($urandom());

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
